// ===== sv/assert_macros.svh =====
// shared assertion macros for the line rasterizer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside of reset
`define BLR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every clock edge, reset included
`define BLR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/blr_pkg.sv =====
`timescale 1ns / 1ps

package blr_pkg;

  // coordinate width, tile side is 2^COORD_BITS
  localparam int COORD_BITS = 6;

  // stream payload widths, padded to whole bytes
  localparam int IN_FIELD_BITS  = 4 * COORD_BITS;
  localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = 2 * COORD_BITS;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  // error accumulator holds up to twice the major delta
  localparam int ERR_BITS = COORD_BITS + 1;

  // segment queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [ERR_BITS-1:0]   err_t;

  // classified segment, ready to walk
  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t major;
    coord_t minor;
    logic   x_major;
    logic   x_down;
    logic   y_down;
  } seg_desc_t;

endpackage

// ===== sv/blr_front.sv =====
`timescale 1ns / 1ps

module blr_front (
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [blr_pkg::IN_DATA_BITS-1:0] s_axis_tdata,
  input  logic                    q_full,
  output logic                    q_push,
  output blr_pkg::seg_desc_t      q_desc
);
  import blr_pkg::*;

  coord_t sx, sy, ex, ey;
  coord_t dx, dy;
  logic   xdown, ydown, xm;

  // unpack endpoints from the lowest bits up
  assign sx = s_axis_tdata[COORD_BITS-1:0];
  assign sy = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
  assign ex = s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
  assign ey = s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS];

  // direction and absolute deltas, zero delta counts as downward
  always_comb begin
    xdown = !(ex > sx);
    ydown = !(ey > sy);
    dx    = xdown ? coord_t'(sx - ex) : coord_t'(ex - sx);
    dy    = ydown ? coord_t'(sy - ey) : coord_t'(ey - sy);
    xm    = dx > dy;
  end

  // descriptor for the walker, x is major only on a strict win
  always_comb begin
    q_desc.start_x = sx;
    q_desc.start_y = sy;
    q_desc.major   = xm ? dx : dy;
    q_desc.minor   = xm ? dy : dx;
    q_desc.x_major = xm;
    q_desc.x_down  = xdown;
    q_desc.y_down  = ydown;
  end

  // take a segment whenever the queue has room
  assign s_axis_tready = !q_full;
  assign q_push        = s_axis_tvalid && s_axis_tready;

endmodule

// ===== sv/blr_queue.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module blr_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  blr_pkg::seg_desc_t push_desc,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output blr_pkg::seg_desc_t head_desc
);
  import blr_pkg::*;

  seg_desc_t            entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;
  logic                 do_push;
  logic                 do_pop;

  assign full       = count == QCNT_BITS'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_desc  = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  `BLR_ASSERT(a_count_bound, count <= QCNT_BITS'(QUEUE_DEPTH), "queue count past depth")
  `BLR_ASSERT(a_no_push_full, full |-> !push, "push into full queue")
  `BLR_ASSERT(a_pop_empty, pop |-> head_valid, "pop from empty queue")

endmodule

// ===== sv/blr_walk.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module blr_walk (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  blr_pkg::seg_desc_t q_desc,
  output logic               q_pop,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [blr_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
  output logic               m_axis_tlast
);
  import blr_pkg::*;

  // walk state: next pixel to emit and pixels left after it
  logic   busy;
  coord_t cur_x;
  coord_t cur_y;
  err_t   err;
  coord_t rem;
  coord_t major;
  coord_t minor;
  logic   x_major;
  logic   x_down;
  logic   y_down;

  // output register
  coord_t pix_x;
  coord_t pix_y;
  logic   pix_last;

  // selected source: live walk or a fresh segment from the queue
  coord_t src_x, src_y, src_rem, src_major, src_minor;
  err_t   src_err;
  logic   src_xm, src_xd, src_yd;

  logic   out_load;
  logic   start;
  logic   emit;
  err_t   err_sum;
  logic   hit;
  coord_t step_x;
  coord_t step_y;
  coord_t nxt_x;
  coord_t nxt_y;
  err_t   nxt_err;

  assign out_load = !m_axis_tvalid || m_axis_tready;
  assign start    = !busy && q_valid && out_load;
  assign emit     = start || (busy && out_load);
  assign q_pop    = start;

  always_comb begin
    if (busy) begin
      src_x     = cur_x;
      src_y     = cur_y;
      src_err   = err;
      src_rem   = rem;
      src_major = major;
      src_minor = minor;
      src_xm    = x_major;
      src_xd    = x_down;
      src_yd    = y_down;
    end else begin
      src_x     = q_desc.start_x;
      src_y     = q_desc.start_y;
      src_err   = err_t'({1'b0, q_desc.major} >> 1);
      src_rem   = q_desc.major;
      src_major = q_desc.major;
      src_minor = q_desc.minor;
      src_xm    = q_desc.x_major;
      src_xd    = q_desc.x_down;
      src_yd    = q_desc.y_down;
    end
  end

  // one bresenham step: major axis always moves, minor on overflow
  always_comb begin
    err_sum = src_err + {1'b0, src_minor};
    hit     = err_sum >= {1'b0, src_major};
    nxt_err = hit ? err_t'(err_sum - {1'b0, src_major}) : err_sum;
    step_x  = src_xd ? coord_t'(src_x - 1'b1) : coord_t'(src_x + 1'b1);
    step_y  = src_yd ? coord_t'(src_y - 1'b1) : coord_t'(src_y + 1'b1);
    if (src_xm) begin
      nxt_x = step_x;
      nxt_y = hit ? step_y : src_y;
    end else begin
      nxt_x = hit ? step_x : src_x;
      nxt_y = step_y;
    end
  end

  // control: walk flag and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= emit;
      end
      if (emit) begin
        busy <= src_rem != '0;
      end
    end
  end

  // payload: pixel out and walk advance
  always_ff @(posedge clk) begin
    if (emit) begin
      pix_x    <= src_x;
      pix_y    <= src_y;
      pix_last <= src_rem == '0;
      cur_x    <= nxt_x;
      cur_y    <= nxt_y;
      err      <= nxt_err;
      rem      <= src_rem - coord_t'(1);
    end
    if (start) begin
      major   <= q_desc.major;
      minor   <= q_desc.minor;
      x_major <= q_desc.x_major;
      x_down  <= q_desc.x_down;
      y_down  <= q_desc.y_down;
    end
  end

  assign m_axis_tdata = OUT_DATA_BITS'({pix_y, pix_x});
  assign m_axis_tlast = pix_last;

  `BLR_ASSERT(a_err_below_major, busy |-> err < {1'b0, major}, "error past major delta")
  `BLR_ASSERT(a_rem_below_major, busy |-> rem < major, "pixel count past major delta")
  `BLR_ASSERT(a_end_flagged, busy && out_load && rem == '0 |=> m_axis_tvalid && m_axis_tlast && !busy, "segment end not flagged")

endmodule

// ===== sv/bresenham_line_raster.sv =====
`timescale 1ns / 1ps
// the first pixel of a segment passes through the segment queue and then the output register
//   before it is offered on the output
// throughput: one pixel a cycle while the output is not stalled, from the single step unit
//   of the walker; each segment gives max(|dx|,|dy|)+1 pixels, with no gap between segments
// up to two classified segments wait in the queue while a walk is under way
// reset: synchronous, active high, empties the queue and drops any walk in progress

module bresenham_line_raster (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // start_x, start_y, end_x, end_y from bit 0 up, zero padded
  input  logic [blr_pkg::IN_DATA_BITS-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // pixel_x, pixel_y from bit 0 up, zero padded
  output logic [blr_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
  output logic m_axis_tlast
);
  import blr_pkg::*;

  logic      q_full;
  logic      q_push;
  seg_desc_t q_in;
  logic      q_pop;
  logic      q_valid;
  seg_desc_t q_head;

  // classify incoming segments
  blr_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_desc        (q_in)
  );

  // segment queue
  blr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_desc  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_desc  (q_head)
  );

  // pixel walker
  blr_walk u_walk (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_desc        (q_head),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
